// ===== rtl/core/ssbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbs_pkg
// Shared types and constants for the sorted store with binary search.
// ----------------------------------------------------------------------------
package ssbs_pkg;

  localparam int DEPTH       = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 6;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                          func;
    logic                          start_new;
    logic signed [VALUE_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             overflow;
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  // Which address the store is read at in a given cycle.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_JM1,
    RD_JM2,
    RD_MID
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    rd_sel_t rd_sel;
    logic    ld_step;
    logic    sr_step;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_search;
    logic overflow;
    logic ld_last;
    logic range_empty;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/ssbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssbs_ctrl
// Controller: sequences the insertion of a load and the probes of a search.
// ----------------------------------------------------------------------------
module ssbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssbs_pkg::dp_sts_t sts,
  output ssbs_pkg::dp_cmd_t cmd
);
  import ssbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LD_SHIFT,
    S_SR_RD,
    S_SR_CMP,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_search) begin
          state_nxt = S_SR_RD;
        end else if (sts.overflow) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.rd_sel = RD_JM1;
          state_nxt  = S_LD_SHIFT;
        end
      end
      S_LD_SHIFT: begin
        // The read of the next lower entry is issued every step; it is
        // simply unused on the last one.
        cmd.ld_step = 1'b1;
        cmd.rd_sel  = RD_JM2;
        if (sts.ld_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_SR_RD: begin
        if (sts.range_empty) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.rd_sel = RD_MID;
          state_nxt  = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        cmd.sr_step = 1'b1;
        state_nxt   = sts.hit ? S_RESULT : S_SR_RD;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ===== rtl/core/ssbs_dp.sv =====
// ----------------------------------------------------------------------------
// ssbs_dp
// Datapath: element store kept in ascending order, insertion and search
// registers, and the result register.
// ----------------------------------------------------------------------------
module ssbs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ssbs_pkg::in_item_t  in_data,
  input  ssbs_pkg::dp_cmd_t   cmd,
  output ssbs_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output ssbs_pkg::out_item_t out_data
);
  import ssbs_pkg::*;

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

  logic signed [VALUE_WIDTH-1:0] key_r;
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic                          func_r;
  logic                          ovf_r;
  logic                          found_r;
  logic [POS_W-1:0]              pos_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              j_r;
  logic [CNT_W-1:0]              lo_r;
  logic [CNT_W-1:0]              hi_r;
  logic [ADDR_W-1:0]             mid_r;
  logic                          out_valid_r;
  out_item_t                     out_data_r;

  logic [ADDR_W-1:0]             rd_addr;
  logic                          rd_en;
  logic [CNT_W:0]                mid_sum;
  logic [ADDR_W-1:0]             mid_calc;
  logic                          probe_gt_key;
  logic                          hit;
  logic                          ld_last;
  logic                          we;
  logic [ADDR_W-1:0]             wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;

  // Floor midpoint of the inclusive range [lo, hi-1].
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - {{CNT_W{1'b0}}, 1'b1};
  assign mid_calc = ADDR_W'(mid_sum >> 1);

  always_comb begin
    case (cmd.rd_sel)
      RD_JM1:  rd_addr = ADDR_W'(j_r - CNT_W'(1));
      RD_JM2:  rd_addr = ADDR_W'(j_r - CNT_W'(2));
      RD_MID:  rd_addr = mid_calc;
      default: rd_addr = '0;
    endcase
  end

  assign rd_en = (cmd.rd_sel != RD_NONE);

  assign probe_gt_key = (rd_data_r > key_r);
  assign hit          = (rd_data_r == key_r);
  assign ld_last      = (j_r == '0) || !probe_gt_key;

  // Each insertion step either moves a larger entry up one place or drops
  // the new value into the hole.
  assign we      = cmd.ld_step;
  assign wr_addr = ADDR_W'(j_r);
  assign wr_data = ld_last ? key_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture && (in_data.func == FUNC_LOAD) && in_data.start_new) begin
        count_r <= '0;
      end else if (cmd.ld_step && ld_last) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r   <= in_data.value;
      func_r  <= in_data.func;
      ovf_r   <= (in_data.func == FUNC_LOAD) && !in_data.start_new &&
                 (count_r == CNT_W'(DEPTH));
      j_r     <= in_data.start_new ? '0 : count_r;
      lo_r    <= '0;
      hi_r    <= count_r;
      found_r <= 1'b0;
      pos_r   <= '0;
    end else if (cmd.ld_step && !ld_last) begin
      j_r <= j_r - CNT_W'(1);
    end else if (cmd.sr_step) begin
      if (hit) begin
        found_r <= 1'b1;
        pos_r   <= POS_W'(CNT_W'(mid_r) + CNT_W'(1));
      end else if (!probe_gt_key) begin
        lo_r <= CNT_W'(mid_r) + CNT_W'(1);
      end else begin
        hi_r <= CNT_W'(mid_r);
      end
    end
    if (cmd.rd_sel == RD_MID) begin
      mid_r <= mid_calc;
    end
    if (cmd.out_load) begin
      out_data_r.overflow <= ovf_r;
      out_data_r.found    <= found_r;
      out_data_r.position <= pos_r;
    end
  end

  always_comb begin
    sts.is_search   = (func_r == FUNC_SEARCH);
    sts.overflow    = ovf_r;
    sts.ld_last     = ld_last;
    sts.range_empty = (lo_r >= hi_r);
    sts.hit         = hit;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/sorted_store_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_store_binary_search
// Store of signed values kept in ascending order, with binary search.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Beat
//   in_      input      in_valid/in_stall   func, start_new, value
//   out_     output     out_valid/out_stall overflow, found, position
//
// Each load is inserted in order as it arrives, one store entry moved per
// cycle; the store has a single read port. One item is in work at a time;
// a finished result waits in the output register while the next beat is
// taken. Reset empties the store.
//
module sorted_store_binary_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ssbs_pkg::out_item_t out_data
);
  import ssbs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ssbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
